@@ sv/seven_segment_two_wire_writer_top_assert.svh @@
// Assertion macros for the seven-segment two-wire writer.
`ifndef SEVEN_SEGMENT_TWO_WIRE_WRITER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSWW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seven segment writer: implication failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SSWW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seven segment writer: next-cycle check failed");

`endif

@@ sv/ssww_pkg.sv @@
// Package: payload types, command bytes and segment table for the display writer.
`timescale 1ns / 1ps
`default_nettype none

package ssww_pkg;

    localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] CMD_CONTROL    = 8'h80;
    localparam logic [7:0] SEG_BLANK      = 8'h00;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ON = 1'd1;

    typedef struct packed {
        logic       start_request;
        logic [2:0] position;
        logic [3:0] digit;
        logic       dio_sample;
    } in_t;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic done_res;
    } out_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

@@ sv/seven_segment_two_wire_writer_top.sv @@
// Channel    | Direction | Handshake          | Payload
// in         | input     | in_valid/in_stall  | in_data (in_t): request, position, digit, sample
// out        | output    | out_valid/out_stall| out_data (out_t): pin levels, busy, done
// cfg        | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input transaction (tick) per cycle while in_stall is low; its result is registered.
// The step sequencer is a single state register updated once per accepted tick.
// A two-entry output stage (result register plus skid) absorbs one result while out_stall is high;
// in_stall comes straight from the skid register.
// Reset: sequencer idle, both pins high, brightness 0, display on; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_two_wire_writer_top
    import ssww_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_t                        out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE           = 4'd0,
        ST_START_DIO_HIGH = 4'd1,
        ST_START_CLK_HIGH = 4'd2,
        ST_START_DIO_LOW  = 4'd3,
        ST_START_CLK_LOW  = 4'd4,
        ST_BIT_CLK_LOW    = 4'd5,
        ST_BIT_DIO        = 4'd6,
        ST_BIT_CLK_HIGH   = 4'd7,
        ST_ACK_CLK_LOW    = 4'd8,
        ST_ACK_RELEASE    = 4'd9,
        ST_ACK_CLK_HIGH   = 4'd10,
        ST_ACK_WAIT       = 4'd11,
        ST_STOP_CLK_LOW   = 4'd12,
        ST_STOP_DIO_LOW   = 4'd13,
        ST_STOP_CLK_HIGH  = 4'd14,
        ST_STOP_DIO_HIGH  = 4'd15
    } step_t;

    step_t      step_reg, step_next, step_cur;
    logic [1:0] xact_reg, xact_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] addr_reg, addr_next;
    logic [7:0] seg_reg, seg_next;
    logic       clock_pin_reg, clock_pin_next;
    logic       data_pin_reg, data_pin_next;
    logic [2:0] brightness_reg, brightness_next;
    logic       display_on_reg, display_on_next;

    out_t       out_reg, out_next;
    out_t       skid_reg, skid_next;
    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;

    logic       accept;
    logic       out_fire;
    logic       cfg_write;
    logic       busy;
    logic       done;
    logic [7:0] byte_sel;
    out_t       result;

    assign accept    = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_write = cfg_valid && cfg_ready;

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (xact_reg)
            2'd0:    byte_sel = CMD_DATA_FIXED;
            2'd1:    byte_sel = CMD_ADDRESS | {5'd0, addr_reg};
            2'd2:    byte_sel = seg_reg;
            default: byte_sel = CMD_CONTROL | {4'd0, display_on_reg, brightness_reg};
        endcase
    end

    always_comb
    begin
        step_cur       = step_reg;
        xact_next      = xact_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        addr_next      = addr_reg;
        seg_next       = seg_reg;
        clock_pin_next = clock_pin_reg;
        data_pin_next  = data_pin_reg;
        done           = 1'b0;

        if (step_reg == ST_IDLE && in_data.start_request)
        begin
            addr_next = in_data.position;
            seg_next  = seg_pattern(in_data.digit);
            xact_next = 2'd0;
            step_cur  = ST_START_DIO_HIGH;
        end
        busy      = (step_cur != ST_IDLE);
        step_next = step_cur;

        unique case (step_cur)
            ST_IDLE:
            begin
                step_next = ST_IDLE;
            end
            ST_START_DIO_HIGH:
            begin
                data_pin_next = 1'b1;
                step_next     = ST_START_CLK_HIGH;
            end
            ST_START_CLK_HIGH:
            begin
                clock_pin_next = 1'b1;
                step_next      = ST_START_DIO_LOW;
            end
            ST_START_DIO_LOW:
            begin
                data_pin_next = 1'b0;
                step_next     = ST_START_CLK_LOW;
            end
            ST_START_CLK_LOW:
            begin
                clock_pin_next = 1'b0;
                shift_next     = byte_sel;
                bit_index_next = 4'd0;
                step_next      = ST_BIT_CLK_LOW;
            end
            ST_BIT_CLK_LOW:
            begin
                clock_pin_next = 1'b0;
                step_next      = ST_BIT_DIO;
            end
            ST_BIT_DIO:
            begin
                data_pin_next = shift_reg[0];
                shift_next    = {1'b0, shift_reg[7:1]};
                step_next     = ST_BIT_CLK_HIGH;
            end
            ST_BIT_CLK_HIGH:
            begin
                clock_pin_next = 1'b1;
                bit_index_next = bit_index_reg + 4'd1;
                step_next      = bit_index_next[3] ? ST_ACK_CLK_LOW : ST_BIT_CLK_LOW;
            end
            ST_ACK_CLK_LOW:
            begin
                clock_pin_next = 1'b0;
                step_next      = ST_ACK_RELEASE;
            end
            ST_ACK_RELEASE:
            begin
                data_pin_next = 1'b1;
                step_next     = ST_ACK_CLK_HIGH;
            end
            ST_ACK_CLK_HIGH:
            begin
                clock_pin_next = 1'b1;
                step_next      = ST_ACK_WAIT;
            end
            ST_ACK_WAIT:
            begin
                if (!in_data.dio_sample)
                begin
                    clock_pin_next = 1'b0;
                    if (xact_reg == 2'd1)
                    begin
                        // address byte is followed by the segment byte in the same frame
                        xact_next      = 2'd2;
                        shift_next     = seg_reg;
                        bit_index_next = 4'd0;
                        step_next      = ST_BIT_CLK_LOW;
                    end
                    else
                    begin
                        step_next = ST_STOP_CLK_LOW;
                    end
                end
            end
            ST_STOP_CLK_LOW:
            begin
                clock_pin_next = 1'b0;
                step_next      = ST_STOP_DIO_LOW;
            end
            ST_STOP_DIO_LOW:
            begin
                data_pin_next = 1'b0;
                step_next     = ST_STOP_CLK_HIGH;
            end
            ST_STOP_CLK_HIGH:
            begin
                clock_pin_next = 1'b1;
                step_next      = ST_STOP_DIO_HIGH;
            end
            ST_STOP_DIO_HIGH:
            begin
                data_pin_next = 1'b1;
                if (xact_reg == 2'd3)
                begin
                    done      = 1'b1;
                    xact_next = 2'd0;
                    step_next = ST_IDLE;
                end
                else
                begin
                    xact_next = xact_reg + 2'd1;
                    step_next = ST_START_DIO_HIGH;
                end
            end
        endcase

        result.clk_level = clock_pin_next;
        result.dio_level = data_pin_next;
        result.busy_res  = busy;
        result.done_res  = done;
    end

    always_comb
    begin
        brightness_next = brightness_reg;
        display_on_next = display_on_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: brightness_next = cfg_data;
                CFG_DISPLAY_ON: display_on_next = cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_IDLE;
            xact_reg       <= 2'd0;
            bit_index_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            addr_reg       <= 3'd0;
            seg_reg        <= 8'd0;
            clock_pin_reg  <= 1'b1;
            data_pin_reg   <= 1'b1;
            brightness_reg <= 3'd0;
            display_on_reg <= 1'b1;
            out_reg        <= '0;
            skid_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                step_reg      <= step_next;
                xact_reg      <= xact_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                addr_reg      <= addr_next;
                seg_reg       <= seg_next;
                clock_pin_reg <= clock_pin_next;
                data_pin_reg  <= data_pin_next;
            end
            brightness_reg <= brightness_next;
            display_on_reg <= display_on_next;
            out_reg        <= out_next;
            skid_reg       <= skid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    `include "seven_segment_two_wire_writer_top_assert.svh"

    `SSWW_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `SSWW_ASSERT_NXT(a_done_goes_idle, accept && done, step_reg == ST_IDLE)
    `SSWW_ASSERT_NXT(a_hold_without_tick, !accept, $stable(step_reg) && $stable(clock_pin_reg))
    `SSWW_ASSERT_NXT(a_idle_pins_hold, accept && !busy,
        $stable(clock_pin_reg) && $stable(data_pin_reg) && step_reg == ST_IDLE)
    `SSWW_ASSERT_NXT(a_ack_wait_holds,
        accept && step_reg == ST_ACK_WAIT && in_data.dio_sample, step_reg == ST_ACK_WAIT)

endmodule

`default_nettype wire
